// ===== rtl/pearson_correlation_accumulator_core_defines.svh =====
// Assertion macros for the one RTL file that carries checks, the top-level core.
`ifndef PEARSON_CORRELATION_ACCUMULATOR_CORE_DEFINES_SVH
`define PEARSON_CORRELATION_ACCUMULATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PCC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcc assertion failed");
`define PCC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcc assertion failed");
`else
`define PCC_ASSERT_IMP(label, clk, rst, ante, cons)
`define PCC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/pcc_pkg.sv =====
package pcc_pkg;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_WAIT,
    BK_FIN
  } back_state_t;

  typedef enum logic [3:0] {
    ST_NSXY,
    ST_SXSY,
    ST_NSXX,
    ST_SXSX,
    ST_NSYY,
    ST_SYSY,
    ST_DEN,
    ST_RHS,
    ST_KSQ,
    ST_KDEN
  } mul_step_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO_VAR = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam int QUEUE_DEPTH = 2;

endpackage

// ===== rtl/pcc_fifo.sv =====
module pcc_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic          pop,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata,
  output logic          full,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] used;
  logic          do_push;
  logic          do_pop;

  assign full    = (used == CW'(DEPTH));
  assign empty   = (used == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   used <= used + 1'b1;
        2'b01:   used <= used - 1'b1;
        default: used <= used;
      endcase
    end
  end

endmodule

// ===== rtl/pcc_front.sv =====
module pcc_front #(
  parameter int SB = 16,
  parameter int ML = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic signed [SB-1:0]   x_sample,
  input  logic signed [SB-1:0]   y_sample,
  input  logic                   last_pair,
  output logic                   job_push,
  output logic [ML:0]            job_count,
  output logic [SB+ML-1:0]       job_sx,
  output logic [SB+ML-1:0]       job_sy,
  output logic [2*SB+ML-2:0]     job_sxx,
  output logic [2*SB+ML-2:0]     job_syy,
  output logic [2*SB+ML-1:0]     job_sxy,
  output logic                   job_ovf
);

  localparam int SW = SB + ML;
  localparam int XW = 2 * SB + ML - 1;
  localparam int PW = 2 * SB + ML;

  logic [ML:0]          count;
  logic [SW-1:0]        sum_x;
  logic [SW-1:0]        sum_y;
  logic [XW-1:0]        sum_xx;
  logic [XW-1:0]        sum_yy;
  logic [PW-1:0]        sum_xy;
  logic                 overflow;

  logic [ML:0]          count_next;
  logic [SW-1:0]        sum_x_next;
  logic [SW-1:0]        sum_y_next;
  logic [XW-1:0]        sum_xx_next;
  logic [XW-1:0]        sum_yy_next;
  logic [PW-1:0]        sum_xy_next;
  logic                 overflow_next;

  logic signed [2*SB-1:0] prod_xx;
  logic signed [2*SB-1:0] prod_yy;
  logic signed [2*SB-1:0] prod_xy;
  logic                   take;

  assign prod_xx = x_sample * x_sample;
  assign prod_yy = y_sample * y_sample;
  assign prod_xy = x_sample * y_sample;
  assign take    = !count[ML];

  always_comb begin
    count_next    = count;
    sum_x_next    = sum_x;
    sum_y_next    = sum_y;
    sum_xx_next   = sum_xx;
    sum_yy_next   = sum_yy;
    sum_xy_next   = sum_xy;
    overflow_next = overflow;
    if (take) begin
      count_next  = count + 1'b1;
      sum_x_next  = sum_x + {{ML{x_sample[SB-1]}}, x_sample};
      sum_y_next  = sum_y + {{ML{y_sample[SB-1]}}, y_sample};
      sum_xx_next = sum_xx + {{(ML-1){1'b0}}, prod_xx};
      sum_yy_next = sum_yy + {{(ML-1){1'b0}}, prod_yy};
      sum_xy_next = sum_xy + {{ML{prod_xy[2*SB-1]}}, prod_xy};
    end else begin
      overflow_next = 1'b1;
    end
  end

  assign job_push  = accept && last_pair;
  assign job_count = count_next;
  assign job_sx    = sum_x_next;
  assign job_sy    = sum_y_next;
  assign job_sxx   = sum_xx_next;
  assign job_syy   = sum_yy_next;
  assign job_sxy   = sum_xy_next;
  assign job_ovf   = overflow_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      sum_x    <= '0;
      sum_y    <= '0;
      sum_xx   <= '0;
      sum_yy   <= '0;
      sum_xy   <= '0;
      overflow <= 1'b0;
    end else if (accept) begin
      if (last_pair) begin
        count    <= '0;
        sum_x    <= '0;
        sum_y    <= '0;
        sum_xx   <= '0;
        sum_yy   <= '0;
        sum_xy   <= '0;
        overflow <= 1'b0;
      end else begin
        count    <= count_next;
        sum_x    <= sum_x_next;
        sum_y    <= sum_y_next;
        sum_xx   <= sum_xx_next;
        sum_yy   <= sum_yy_next;
        sum_xy   <= sum_xy_next;
        overflow <= overflow_next;
      end
    end
  end

endmodule

// ===== rtl/pcc_mul.sv =====
module pcc_mul #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] product
);

  logic         run;
  logic [W-1:0] ma;
  logic [W-1:0] mb;
  logic [W-1:0] acc;

  assign done    = run && (mb == '0);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start && !run) begin
      run <= 1'b1;
    end else if (done) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !run) begin
      ma  <= a;
      mb  <= b;
      acc <= '0;
    end else if (run && (mb != '0)) begin
      if (mb[0]) begin
        acc <= acc + ma;
      end
      ma <= ma << 1;
      mb <= mb >> 1;
    end
  end

endmodule

// ===== rtl/pcc_back.sv =====
module pcc_back
  import pcc_pkg::*;
#(
  parameter int SB = 16,
  parameter int ML = 20,
  parameter int F  = 15
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   job_valid,
  input  logic [ML:0]            job_count,
  input  logic [SB+ML-1:0]       job_sx,
  input  logic [SB+ML-1:0]       job_sy,
  input  logic [2*SB+ML-2:0]     job_sxx,
  input  logic [2*SB+ML-2:0]     job_syy,
  input  logic [2*SB+ML-1:0]     job_sxy,
  input  logic                   job_ovf,
  output logic                   job_pop,
  input  logic                   pop,
  output logic                   res_valid,
  output logic [F:0]             res_corr,
  output logic [1:0]             res_status,
  output logic [ML:0]            res_count
);

  localparam int CB = ML + 1;
  localparam int SW = SB + ML;
  localparam int XW = 2 * SB + ML - 1;
  localparam int PW = 2 * SB + ML;
  localparam int W  = 4 * SB + 4 * ML + 2 * F + 2;
  localparam int KW = F + 2;
  localparam int BW = $clog2(F + 2);

  back_state_t  state;
  back_state_t  state_next;
  mul_step_t    step;

  logic [CB-1:0] n;
  logic [SW-1:0] sx;
  logic [SW-1:0] sy;
  logic [XW-1:0] sxx;
  logic [XW-1:0] syy;
  logic [PW-1:0] sxy;
  logic [W-1:0]  t1;
  logic [W-1:0]  num;
  logic [W-1:0]  dx;
  logic [W-1:0]  dy;
  logic [W-1:0]  den;
  logic [W-1:0]  rhs;
  logic [KW-1:0] k;
  logic [BW-1:0] bit_idx;
  logic [1:0]    status;

  logic          mul_start;
  logic          mul_done;
  logic          res_load;
  logic [W-1:0]  prod;
  logic [W-1:0]  prod_neg;
  logic [W-1:0]  op_a;
  logic [W-1:0]  op_b;
  logic [SW-1:0] sx_mag;
  logic [SW-1:0] sy_mag;
  logic [PW-1:0] sxy_mag;
  logic          num_neg;
  logic [W-1:0]  num_mag;
  logic [W-1:0]  a_mag;
  logic [KW-1:0] cand;
  logic [KW:0]   k_inc;
  logic [KW-1:0] q;
  logic [KW-1:0] q_sat;
  logic [KW-1:0] corr_val;
  logic [KW-1:0] top;

  assign sx_mag   = sx[SW-1] ? (~sx + 1'b1) : sx;
  assign sy_mag   = sy[SW-1] ? (~sy + 1'b1) : sy;
  assign sxy_mag  = sxy[PW-1] ? (~sxy + 1'b1) : sxy;
  assign num_neg  = num[W-1];
  assign num_mag  = num_neg ? (~num + 1'b1) : num;
  assign a_mag    = num_mag << F;
  assign prod_neg = ~prod + 1'b1;
  assign cand     = k | (KW'(1) << bit_idx);
  assign k_inc    = {1'b0, k} + 1'b1;
  assign q        = k_inc[KW:1];
  assign top      = {2'b00, {F{1'b1}}};
  assign q_sat    = (!num_neg && (q > top)) ? top : q;
  assign corr_val = num_neg ? (~q_sat + 1'b1) : q_sat;

  always_comb begin
    case (step)
      ST_NSXY: begin
        op_a = W'(sxy_mag);
        op_b = W'(n);
      end
      ST_SXSY: begin
        op_a = W'(sx_mag);
        op_b = W'(sy_mag);
      end
      ST_NSXX: begin
        op_a = W'(sxx);
        op_b = W'(n);
      end
      ST_SXSX: begin
        op_a = W'(sx_mag);
        op_b = W'(sx_mag);
      end
      ST_NSYY: begin
        op_a = W'(syy);
        op_b = W'(n);
      end
      ST_SYSY: begin
        op_a = W'(sy_mag);
        op_b = W'(sy_mag);
      end
      ST_DEN: begin
        op_a = dx;
        op_b = dy;
      end
      ST_RHS: begin
        op_a = a_mag;
        op_b = a_mag;
      end
      ST_KSQ: begin
        op_a = W'(cand);
        op_b = W'(cand);
      end
      ST_KDEN: begin
        op_a = den;
        op_b = t1;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  pcc_mul #(.W(W)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (op_a),
    .b       (op_b),
    .done    (mul_done),
    .product (prod)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (job_valid) begin
          state_next = job_ovf ? BK_FIN : BK_ISSUE;
        end
      end
      BK_ISSUE: begin
        state_next = BK_WAIT;
      end
      BK_WAIT: begin
        if (mul_done) begin
          if ((step == ST_DEN) && (prod == '0)) begin
            state_next = BK_FIN;
          end else if ((step == ST_KDEN) && (bit_idx == '0)) begin
            state_next = BK_FIN;
          end else begin
            state_next = BK_ISSUE;
          end
        end
      end
      BK_FIN: begin
        if (!res_valid || pop) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop   = (state == BK_IDLE) && job_valid;
    mul_start = (state == BK_ISSUE);
    res_load  = (state == BK_FIN) && (!res_valid || pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      n      <= job_count;
      sx     <= job_sx;
      sy     <= job_sy;
      sxx    <= job_sxx;
      syy    <= job_syy;
      sxy    <= job_sxy;
      step   <= ST_NSXY;
      status <= job_ovf ? STATUS_OVERFLOW : STATUS_OK;
      k      <= '0;
    end else if ((state == BK_WAIT) && mul_done) begin
      case (step)
        ST_NSXY: begin
          t1   <= sxy[PW-1] ? prod_neg : prod;
          step <= ST_SXSY;
        end
        ST_SXSY: begin
          num  <= t1 - ((sx[SW-1] ^ sy[SW-1]) ? prod_neg : prod);
          step <= ST_NSXX;
        end
        ST_NSXX: begin
          t1   <= prod;
          step <= ST_SXSX;
        end
        ST_SXSX: begin
          dx   <= t1 - prod;
          step <= ST_NSYY;
        end
        ST_NSYY: begin
          t1   <= prod;
          step <= ST_SYSY;
        end
        ST_SYSY: begin
          dy   <= t1 - prod;
          step <= ST_DEN;
        end
        ST_DEN: begin
          den <= prod;
          if (prod == '0) begin
            status <= STATUS_ZERO_VAR;
          end
          step <= ST_RHS;
        end
        ST_RHS: begin
          rhs     <= prod << 2;
          k       <= '0;
          bit_idx <= BW'(F + 1);
          step    <= ST_KSQ;
        end
        ST_KSQ: begin
          t1   <= prod;
          step <= ST_KDEN;
        end
        ST_KDEN: begin
          if (prod <= rhs) begin
            k <= cand;
          end
          if (bit_idx != '0) begin
            bit_idx <= bit_idx - 1'b1;
          end
          step <= ST_KSQ;
        end
        default: step <= ST_NSXY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_corr   <= (status == STATUS_OK) ? corr_val[F:0] : '0;
      res_status <= status;
      res_count  <= n;
    end
  end

endmodule

// ===== rtl/pearson_correlation_accumulator_core.sv =====
// Channel  Direction  Handshake         Word
// input    in         push / full       x_sample, y_sample, last_pair
// result   out        empty / pop       correlation, status, pair_count
//
// The front end takes one pair per cycle and stalls whenever both queue slots
// hold finished sets that wait for the back end.
// Finalizing a set runs on one shift-add multiplier, which handles one multiplier
// bit at a time and stops once the remaining multiplier bits are zero.
// Reset is synchronous and clears the sums, the queue and the result-valid flag.
// A waiting result word does not block accumulation of the next set.
`include "pearson_correlation_accumulator_core_defines.svh"

module pearson_correlation_accumulator_core
  import pcc_pkg::*;
#(
  parameter int SAMPLE_BITS      = 16,
  parameter int MAX_PAIRS_LOG2   = 20,
  parameter int RESULT_FRAC_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] x_sample,
  input  logic signed [SAMPLE_BITS-1:0] y_sample,
  input  logic                          last_pair,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [RESULT_FRAC_BITS:0] correlation,
  output logic [1:0]                    status,
  output logic [MAX_PAIRS_LOG2:0]       pair_count
);

  localparam int SB    = SAMPLE_BITS;
  localparam int ML    = MAX_PAIRS_LOG2;
  localparam int CB    = ML + 1;
  localparam int SW    = SB + ML;
  localparam int XW    = 2 * SB + ML - 1;
  localparam int PW    = 2 * SB + ML;
  localparam int JOB_W = CB + 2 * SW + 2 * XW + PW + 1;

  logic             accept;
  logic             f_push;
  logic [CB-1:0]    f_count;
  logic [SW-1:0]    f_sx;
  logic [SW-1:0]    f_sy;
  logic [XW-1:0]    f_sxx;
  logic [XW-1:0]    f_syy;
  logic [PW-1:0]    f_sxy;
  logic             f_ovf;
  logic [JOB_W-1:0] q_wdata;
  logic [JOB_W-1:0] q_rdata;
  logic             q_empty;
  logic             b_pop;
  logic [CB-1:0]    b_count;
  logic [SW-1:0]    b_sx;
  logic [SW-1:0]    b_sy;
  logic [XW-1:0]    b_sxx;
  logic [XW-1:0]    b_syy;
  logic [PW-1:0]    b_sxy;
  logic             b_ovf;
  logic             res_valid;
  logic [RESULT_FRAC_BITS:0] res_corr;

  assign accept  = push && !full;
  assign q_wdata = {f_count, f_sx, f_sy, f_sxx, f_syy, f_sxy, f_ovf};
  assign {b_count, b_sx, b_sy, b_sxx, b_syy, b_sxy, b_ovf} = q_rdata;

  pcc_front #(.SB(SB), .ML(ML)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .x_sample  (x_sample),
    .y_sample  (y_sample),
    .last_pair (last_pair),
    .job_push  (f_push),
    .job_count (f_count),
    .job_sx    (f_sx),
    .job_sy    (f_sy),
    .job_sxx   (f_sxx),
    .job_syy   (f_syy),
    .job_sxy   (f_sxy),
    .job_ovf   (f_ovf)
  );

  pcc_fifo #(.DW(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .pop   (b_pop),
    .wdata (q_wdata),
    .rdata (q_rdata),
    .full  (full),
    .empty (q_empty)
  );

  pcc_back #(.SB(SB), .ML(ML), .F(RESULT_FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (!q_empty),
    .job_count  (b_count),
    .job_sx     (b_sx),
    .job_sy     (b_sy),
    .job_sxx    (b_sxx),
    .job_syy    (b_syy),
    .job_sxy    (b_sxy),
    .job_ovf    (b_ovf),
    .job_pop    (b_pop),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_corr   (res_corr),
    .res_status (status),
    .res_count  (pair_count)
  );

  assign empty       = !res_valid;
  assign correlation = res_corr;

  `PCC_ASSERT_IMP(a_bad_status_zero, clk, rst,
                  !empty && (status != STATUS_OK), correlation == '0)
  `PCC_ASSERT_IMP(a_ovf_at_limit, clk, rst,
                  !empty && (status == STATUS_OVERFLOW), pair_count[MAX_PAIRS_LOG2])
  `PCC_ASSERT_IMP(a_ok_two_pairs, clk, rst,
                  !empty && (status == STATUS_OK), pair_count > 1)

endmodule

// ===== test/pearson_correlation_accumulator_core_tb.sv =====
`default_nettype none

module pearson_correlation_accumulator_core_tb;
  import pcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAIRS = 1 << 20;

  typedef logic signed [199:0] big_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } pair_t;

  typedef struct {
    logic signed [15:0] corr;
    logic [1:0]         stat;
    logic [20:0]        cnt;
  } coeff_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic signed [15:0] x_sample = '0;
  logic signed [15:0] y_sample = '0;
  logic last_pair = 1'b0;
  logic full, empty;
  logic signed [15:0] correlation;
  logic [1:0] status;
  logic [20:0] pair_count;

  pair_t  pending_pairs[$];
  coeff_t expected_coeffs[$];
  int     fails = 0;
  int     pairs_sent = 0;
  int     pairs_made = 0;
  int     sets_done = 0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     stall_mode = 0;

  longint            n_acc;
  logic signed [63:0] sx_acc, sy_acc, sxx_acc, syy_acc, sxy_acc;
  bit                 too_many;

  pearson_correlation_accumulator_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .x_sample(x_sample), .y_sample(y_sample), .last_pair(last_pair),
    .empty(empty), .pop(pop), .correlation(correlation),
    .status(status), .pair_count(pair_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic coeff_t finish_set();
    coeff_t res;
    big_t num, dx, dy, den, a, rhs, t;
    logic [63:0] k, cand;
    bit neg;
    num = big_t'(n_acc) * big_t'(sxy_acc) - big_t'(sx_acc) * big_t'(sy_acc);
    dx = big_t'(n_acc) * big_t'(sxx_acc) - big_t'(sx_acc) * big_t'(sx_acc);
    dy = big_t'(n_acc) * big_t'(syy_acc) - big_t'(sy_acc) * big_t'(sy_acc);
    den = dx * dy;
    res.corr = '0;
    res.cnt = n_acc[20:0];
    if (too_many) begin
      res.stat = STATUS_OVERFLOW;
    end else if (den == 0) begin
      res.stat = STATUS_ZERO_VAR;
    end else begin
      res.stat = STATUS_OK;
      neg = num < 0;
      if (neg) num = -num;
      a = num <<< 15;
      rhs = 4 * a * a;
      k = 0;
      for (int b = 16; b >= 0; b--) begin
        cand = k | (64'd1 << b);
        t = big_t'(cand) * big_t'(cand) * den;
        if ($unsigned(t) <= $unsigned(rhs)) k = cand;
      end
      k = (k + 1) >> 1;
      if (!neg && k > 32767) k = 32767;
      res.corr = neg ? 16'(-k) : 16'(k);
    end
    n_acc = 0;
    sx_acc = 0; sy_acc = 0; sxx_acc = 0; syy_acc = 0; sxy_acc = 0;
    too_many = 0;
    return res;
  endfunction

  task automatic take_pair(input pair_t p);
    if (n_acc < MAX_PAIRS) begin
      sx_acc += p.x;
      sy_acc += p.y;
      sxx_acc += p.x * p.x;
      syy_acc += p.y * p.y;
      sxy_acc += 64'(p.x) * 64'(p.y);
      n_acc++;
    end else begin
      too_many = 1;
    end
    if (p.last) begin
      expected_coeffs.push_back(finish_set());
      sets_done++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        take_pair(pending_pairs.pop_front());
        pairs_sent++;
      end
      if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        push <= 1'b1;
        x_sample <= pending_pairs[0].x;
        y_sample <= pending_pairs[0].y;
        last_pair <= pending_pairs[0].last;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_coeffs.size() == 0) begin
          $error("unexpected result word");
          fails++;
        end else begin
          coeff_t e;
          e = expected_coeffs.pop_front();
          if (correlation !== e.corr) begin
            $error("correlation expected %0d actual %0d", e.corr, correlation);
            fails++;
          end
          if (status !== e.stat) begin
            $error("status expected %0d actual %0d", e.stat, status);
            fails++;
          end
          if (pair_count !== e.cnt) begin
            $error("pair_count expected %0d actual %0d", e.cnt, pair_count);
            fails++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 7) == 0);
        default: pop <= ($urandom_range(0, 63) != 0);
      endcase
    end
  end

  task automatic add_pair(input int x, input int y, input bit last);
    pair_t p;
    p.x = 16'(x);
    p.y = 16'(y);
    p.last = last;
    while (pending_pairs.size() > 64) @(posedge clk);
    pending_pairs.push_back(p);
    pairs_made++;
  endtask

  task automatic add_random_set(input int len);
    int kind, scale, x, y, cx;
    kind = $urandom_range(0, 5);
    scale = ($urandom_range(0, 1) == 0) ? 65535 : $urandom_range(1, 200);
    cx = $urandom_range(0, 65535);
    for (int i = 0; i < len; i++) begin
      x = (scale == 65535) ? $urandom_range(0, 65535) - 32768
                           : $urandom_range(0, 2 * scale) - scale;
      case (kind)
        0: y = x + $urandom_range(0, 20) - 10;
        1: y = -x + $urandom_range(0, 20) - 10;
        2: y = $urandom_range(0, 65535);
        3: begin
          y = x;
          x = cx;
        end
        default: y = (scale == 65535) ? $urandom_range(0, 65535)
                                      : $urandom_range(0, 2 * scale) - scale;
      endcase
      add_pair(x, y, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || push || expected_coeffs.size() > 0)
      @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  initial begin
    n_acc = 0;
    sx_acc = 0; sy_acc = 0; sxx_acc = 0; syy_acc = 0; sxy_acc = 0;
    too_many = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    add_pair(5, 7, 1);
    add_pair(-32768, -32768, 0);
    add_pair(32767, 32767, 1);
    add_pair(-32768, 32767, 0);
    add_pair(32767, -32768, 1);
    add_pair(100, -3, 0);
    add_pair(100, 9, 0);
    add_pair(100, 1, 1);
    add_pair(1, 2, 0);
    add_pair(2, 1, 0);
    add_pair(3, 4, 0);
    add_pair(4, 3, 1);
    add_pair(-1, 0, 0);
    add_pair(0, -1, 0);
    add_pair(32767, 32767, 0);
    add_pair(-32768, 0, 1);
    while (pairs_made < 650) add_random_set(($urandom_range(0, 7) == 0) ?
                                            $urandom_range(20, 120) :
                                            $urandom_range(1, 12));
    wait_drained();
    add_random_set(6);
    add_random_set(1);
    wait_drained();
    $display("Sent %0d pairs in %0d sets: extreme samples, constant and single-pair sets,",
             pairs_sent, sets_done);
    $display("random correlated sets, and random stalls on both sides.");
    if (fails == 0 && expected_coeffs.size() == 0) begin
      $display("** pearson_correlation_accumulator_core: PASSED **");
    end else begin
      $display("** pearson_correlation_accumulator_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("** pearson_correlation_accumulator_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
